/* src/swmm_pkg.sv */
// Shared types and constants for the sliding window min/max block.
// No dependencies; imported by every module of the block.
package swmm_pkg;

    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_W    = 32;
    localparam int WIN_W       = $clog2(WINDOW_MAX + 1);
    localparam int WLEN_W      = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FIND_MAX   = 1'b1;

    // broadcast from the chain controller to every cell
    typedef struct packed {
        logic                       shift;
        logic                       find_max;
        logic signed [SAMPLE_W-1:0] sample;
    } t_cell_ctrl;

endpackage

/* src/swmm_cell.sv */
// One candidate slot of the deque: value plus valid flag, shifted one slot older per sample.
// Depends on swmm_pkg.
module swmm_cell
    import swmm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cell_ctrl                 i_ctrl,
    input  logic                       i_in_valid,
    input  logic signed [SAMPLE_W-1:0] i_in_value,
    output logic                       o_valid,
    output logic signed [SAMPLE_W-1:0] o_value,
    output logic                       o_dom
);

    logic                       r_valid;
    logic signed [SAMPLE_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_value <= i_in_value;
        end
    end

    // candidate is beaten by the incoming sample (ties drop the older one)
    assign o_dom   = i_ctrl.find_max ? (r_value <= i_ctrl.sample) : (r_value >= i_ctrl.sample);
    assign o_valid = r_valid;
    assign o_value = r_value;

endmodule

/* src/swmm_chain.sv */
// Row of candidate cells ordered newest (cell 0) to oldest, with keep and head-select logic.
// Depends on swmm_pkg and swmm_cell.
module swmm_chain
    import swmm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cell_ctrl                 i_ctrl,
    input  logic                       i_start,
    input  logic [WIN_W-1:0]           i_win,
    output logic signed [SAMPLE_W-1:0] o_head
);

    logic [WINDOW_MAX-1:0]      valid;
    logic [WINDOW_MAX-1:0]      dom;
    logic [WINDOW_MAX-1:0]      dom_ok;
    logic [WINDOW_MAX-1:0]      expired;
    logic [WINDOW_MAX-1:0]      kept;
    logic [WINDOW_MAX-1:0]      sel;
    logic signed [SAMPLE_W-1:0] value [WINDOW_MAX];
    logic signed [SAMPLE_W-1:0] head_or;

    assign dom_ok = ~valid | dom;

    genvar k;
    generate
        for (k = 0; k < WINDOW_MAX; k++) begin : g_cell
            logic                       in_valid;
            logic signed [SAMPLE_W-1:0] in_value;

            if (k == 0) begin : g_first
                assign in_valid = 1'b1;
                assign in_value = i_ctrl.sample;
            end else begin : g_rest
                assign in_valid = kept[k-1];
                assign in_value = value[k-1];
            end

            swmm_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctrl     (i_ctrl),
                .i_in_valid (in_valid),
                .i_in_value (in_value),
                .o_valid    (valid[k]),
                .o_value    (value[k]),
                .o_dom      (dom[k])
            );

            // age after this sample is k+1
            assign expired[k] = (WIN_W'(k + 1) >= i_win);

            // drop when every live entry from the newest down to this one is beaten
            assign kept[k] = valid[k] & ~expired[k] & ~(&dom_ok[k:0]) & ~i_start;

            if (k == WINDOW_MAX - 1) begin : g_top_sel
                assign sel[k] = kept[k];
            end else begin : g_sel
                assign sel[k] = kept[k] & ~(|kept[WINDOW_MAX-1:k+1]);
            end
        end
    endgenerate

    // oldest surviving candidate is the head
    always_comb begin
        head_or = '0;
        for (int j = 0; j < WINDOW_MAX; j++) begin
            if (sel[j]) begin
                head_or = head_or | value[j];
            end
        end
    end

    assign o_head = (|kept) ? head_or : i_ctrl.sample;

endmodule

/* src/sliding_window_min_max_top.sv */
// Sliding window minimum / maximum over a signed 32-bit sample stream.
// Input stream: s_tdata = sample (bits 31:0), s_tuser = stream_start (restart before
// this sample). Output stream: m_tdata = window_extreme (bits 31:0).
// Config channel: index 0 = window_len (1..64, 0 acts as 1, larger saturates to 64),
// index 1 = find_max (0 minimum, 1 maximum). Write only while the block is idle.
// Throughput: one sample per cycle while s_tready is high. Every sample updates a row
// of 64 candidate cells; all cells compare against the new sample at once.
// The result for a sample is loaded into the output register by its input transaction.
// No result is produced while the stream position is below window_len - 1 (warm-up
// after reset, after stream_start, and after the 32-bit position counter wraps).
// Reset (synchronous, active low): empties the deque, clears the position, sets
// window_len to 1 and find_max to 0. No clearing pass is needed.
// Stall: a held output register keeps its result; input is still taken in the cycle
// the receiver drains it, otherwise s_tready drops until the result is taken.
module sliding_window_min_max_top
    import swmm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [SAMPLE_W-1:0]   i_s_tdata,   // [31:0] sample
    input  logic                  i_s_tuser,   // [0] stream_start
    // output stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [SAMPLE_W-1:0]   o_m_tdata,   // [31:0] window_extreme
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [WLEN_W-1:0]          r_window_len;
    logic                       r_find_max;
    logic [31:0]                r_pos;
    logic                       r_out_valid;
    logic [SAMPLE_W-1:0]        r_out_data;

    logic                       accept;
    logic                       cfg_write;
    logic [WIN_W-1:0]           win;
    logic [31:0]                cur_pos;
    logic                       produce;
    logic signed [SAMPLE_W-1:0] head;
    t_cell_ctrl                 ctrl;

    assign o_s_tready = ~r_out_valid | i_m_tready;
    assign accept     = i_s_tvalid & o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign cfg_write  = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WLEN_W'(1);
            r_find_max   <= 1'b0;
        end else if (cfg_write) begin
            unique case (i_cfg_index)
                REG_WINDOW_LEN: r_window_len <= i_cfg_data[WLEN_W-1:0];
                REG_FIND_MAX:   r_find_max   <= i_cfg_data[0];
                default:        ;
            endcase
        end
    end

    // effective window: zero acts as one, saturate at the cell count
    always_comb begin
        if (r_window_len == '0) begin
            win = WIN_W'(1);
        end else if (int'(r_window_len) > WINDOW_MAX) begin
            win = WIN_W'(WINDOW_MAX);
        end else begin
            win = WIN_W'(r_window_len);
        end
    end

    assign cur_pos = i_s_tuser ? 32'd0 : r_pos;
    assign produce = (cur_pos >= (32'(win) - 32'd1));

    assign ctrl.shift    = accept;
    assign ctrl.find_max = r_find_max;
    assign ctrl.sample   = $signed(i_s_tdata);

    swmm_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_start (i_s_tuser),
        .i_win   (win),
        .o_head  (head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (accept) begin
            r_pos <= cur_pos + 32'd1;
        end
    end

    // output register: load on a producing transaction, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && produce) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && produce) begin
            r_out_data <= head;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
